/* design/s128_pkg.sv */
// Shared definitions for the 128-bit signed ALU: command codes and the
// controller/datapath command and status structs. No dependencies.
package s128_pkg;

    localparam int W = 128;
    localparam int HW = 64;
    localparam int CNT_W = 7;

    typedef enum logic [3:0] {
        CMD_ADD = 4'd0,
        CMD_SUB = 4'd1,
        CMD_MUL = 4'd2,
        CMD_DIV = 4'd3,
        CMD_MOD = 4'd4,
        CMD_NEG = 4'd5,
        CMD_ABS = 4'd6,
        CMD_CMP = 4'd7,
        CMD_SGN = 4'd8
    } t_cmd;

    // datapath operations issued by the controller
    typedef enum logic [2:0] {
        OP_IDLE   = 3'd0,
        OP_LOAD   = 3'd1,
        OP_SIMPLE = 3'd2,
        OP_MUL    = 3'd3,
        OP_DSTEP  = 3'd4,
        OP_DFIX   = 3'd5
    } t_op;

    typedef struct packed {
        t_op op;
    } t_ctl;

    typedef struct packed {
        logic is_mul;
        logic is_div;
        logic div_zero;
        logic step_last;
        logic mul_last;
    } t_sts;

endpackage

/* design/s128_dp.sv */
// Datapath: operand registers, 32x32 multiply-accumulate unit, restoring
// divider (one quotient bit per cycle) and result formatting. Uses s128_pkg.
module s128_dp import s128_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_ctl                 i_ctl,
    input  logic [3:0]           i_command,
    input  logic [HW-1:0]        i_a_low,
    input  logic signed [HW-1:0] i_a_high,
    input  logic [HW-1:0]        i_b_low,
    input  logic signed [HW-1:0] i_b_high,
    output t_sts                 o_sts,
    output logic [W-1:0]         o_res,
    output logic [1:0]           o_order,
    output logic                 o_dz
);

    logic [3:0]     r_cmd;
    logic [W-1:0]   r_a, r_b, r_acc, r_rem, r_quo;
    logic [CNT_W-1:0] r_cnt;
    logic [3:0]     r_mi;
    logic [W-1:0]   r_res;
    logic [1:0]     r_order;
    logic           r_dz;
    logic           r_an, r_bn;

    logic [W-1:0] a_in, b_in, abs_a, abs_b;
    assign a_in  = {i_a_high, i_a_low};
    assign b_in  = {i_b_high, i_b_low};
    assign abs_a = a_in[W-1] ? (~a_in + W'(1)) : a_in;
    assign abs_b = b_in[W-1] ? (~b_in + W'(1)) : b_in;

    // multiplier: 16 partial products of 32-bit limbs, one a cycle
    logic [1:0] ia, ib;
    logic [31:0] la, lb;
    logic [63:0] prod;
    logic [7:0]  sh;
    logic [W-1:0] pp;
    assign ia   = r_mi[3:2];
    assign ib   = r_mi[1:0];
    assign la   = r_a[32*ia +: 32];
    assign lb   = r_b[32*ib +: 32];
    assign prod = la * lb;
    assign sh   = {({1'b0, ia} + {1'b0, ib}), 5'd0};
    assign pp   = (W'(prod)) << sh;

    // divider step
    logic [W:0]   sh_rem;
    logic [W:0]   diff;
    assign sh_rem = {r_rem, r_acc[W-1]};
    assign diff   = sh_rem - {1'b0, r_b};

    // simple ops
    logic [W-1:0] simp;
    logic [1:0]   ord;
    always_comb begin
        simp = '0;
        ord  = 2'b00;
        case (r_cmd)
            CMD_ADD: simp = r_a + r_b;
            CMD_SUB: simp = r_a - r_b;
            CMD_NEG: simp = ~r_a + W'(1);
            CMD_ABS: simp = r_a[W-1] ? (~r_a + W'(1)) : r_a;
            CMD_CMP: begin
                if ($signed(r_a) < $signed(r_b)) ord = 2'b11;
                else if (r_a != r_b) ord = 2'b01;
            end
            CMD_SGN: begin
                if (r_a[W-1]) ord = 2'b11;
                else if (r_a != '0) ord = 2'b01;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dz <= 1'b0;
        end else begin
            unique case (i_ctl.op)
                OP_LOAD: begin
                    r_cmd <= i_command;
                    r_an  <= a_in[W-1];
                    r_bn  <= b_in[W-1];
                    r_cnt <= '0;
                    r_mi  <= '0;
                    r_quo <= '0;
                    r_rem <= '0;
                    r_dz  <= 1'b0;
                    if (i_command == CMD_DIV || i_command == CMD_MOD) begin
                        r_acc <= abs_a;
                        r_b   <= abs_b;
                        r_a   <= a_in;
                    end else begin
                        r_acc <= '0;
                        r_a   <= a_in;
                        r_b   <= b_in;
                    end
                end
                OP_SIMPLE: begin
                    r_res   <= simp;
                    r_order <= ord;
                    r_dz    <= 1'b0;
                end
                OP_MUL: begin
                    r_acc <= r_acc + pp;
                    r_mi  <= r_mi + 4'd1;
                    if (r_mi == 4'd15) begin
                        r_res   <= r_acc + pp;
                        r_order <= 2'b00;
                    end
                end
                OP_DSTEP: begin
                    r_cnt <= r_cnt + CNT_W'(1);
                    r_acc <= {r_acc[W-2:0], 1'b0};
                    if (!diff[W]) begin
                        r_rem <= diff[W-1:0];
                        r_quo <= {r_quo[W-2:0], 1'b1};
                    end else begin
                        r_rem <= sh_rem[W-1:0];
                        r_quo <= {r_quo[W-2:0], 1'b0};
                    end
                end
                OP_DFIX: begin
                    r_order <= 2'b00;
                    if (r_b == '0) begin
                        r_res <= '0;
                        r_dz  <= 1'b1;
                    end else if (r_cmd == CMD_DIV) begin
                        r_res <= (r_an != r_bn) ? (~r_quo + W'(1)) : r_quo;
                    end else begin
                        r_res <= r_an ? (~r_rem + W'(1)) : r_rem;
                    end
                end
                default: ;
            endcase
        end
    end

    assign o_sts.is_mul    = (r_cmd == CMD_MUL);
    assign o_sts.is_div    = (r_cmd == CMD_DIV) || (r_cmd == CMD_MOD);
    assign o_sts.div_zero  = (r_b == '0);
    assign o_sts.step_last = (r_cnt == CNT_W'(W - 1));
    assign o_sts.mul_last  = (r_mi == 4'd15);
    assign o_res   = r_res;
    assign o_order = r_order;
    assign o_dz    = r_dz;

endmodule

/* design/s128_ctrl.sv */
// Controller state machine: sequences load, simple ops, multiply, divide steps,
// divide fix-up and output handoff. Uses s128_pkg.
module s128_ctrl import s128_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    input  logic i_out_stall,
    input  t_sts i_sts,
    output t_ctl o_ctl,
    output logic o_stall,
    output logic o_valid
);

    typedef enum logic [2:0] {
        S_IDLE, S_DISP, S_MUL, S_DIV, S_FIX, S_OUT
    } t_state;

    t_state r_state, n_state;
    logic   r_valid;

    always_comb begin
        n_state  = r_state;
        o_ctl.op = OP_IDLE;
        unique case (r_state)
            S_IDLE: if (i_valid) begin
                o_ctl.op = OP_LOAD;
                n_state  = S_DISP;
            end
            S_DISP: begin
                if (i_sts.is_mul) n_state = S_MUL;
                else if (i_sts.is_div) n_state = i_sts.div_zero ? S_FIX : S_DIV;
                else begin
                    o_ctl.op = OP_SIMPLE;
                    n_state  = S_OUT;
                end
            end
            S_MUL: begin
                o_ctl.op = OP_MUL;
                if (i_sts.mul_last) n_state = S_OUT;
            end
            S_DIV: begin
                o_ctl.op = OP_DSTEP;
                if (i_sts.step_last) n_state = S_FIX;
            end
            S_FIX: begin
                o_ctl.op = OP_DFIX;
                n_state  = S_OUT;
            end
            S_OUT: if (!i_out_stall) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= (n_state == S_OUT);
        end
    end

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = r_valid;

    a_valid_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> r_state == S_OUT) else $error("valid outside output state");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_out_stall) |=> o_valid) else $error("result dropped");
    a_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> r_state == S_DISP) else $error("accept lost");

endmodule

/* design/signed_int128_alu_with_divider.sv */
// Top level of the 128-bit signed ALU with restoring divider.
// Depends on s128_pkg, s128_ctrl and s128_dp.
//
//  channel | signals                                         | direction
//  input   | i_valid, o_stall, i_command, i_a_*, i_b_*         | in
//  output  | o_valid, i_stall, o_result_*, o_order, o_divide_by_zero | out
//
// Multiply forms sixteen 32x32 partial products on one multiplier; divide and
// modulo take one quotient bit per cycle in the restoring divider, and a zero
// divisor skips the divide steps and goes straight to the fix-up state.
// Reset is synchronous, active low, and clears the controller.
// One word at a time; a stalled result holds until taken.
module signed_int128_alu_with_divider import s128_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic [3:0]           i_command,
    input  logic [HW-1:0]        i_a_low,
    input  logic signed [HW-1:0] i_a_high,
    input  logic [HW-1:0]        i_b_low,
    input  logic signed [HW-1:0] i_b_high,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic [HW-1:0]        o_result_low,
    output logic signed [HW-1:0] o_result_high,
    output logic signed [1:0]    o_order,
    output logic                 o_divide_by_zero
);

    t_ctl ctl;
    t_sts sts;
    logic [W-1:0] res;
    logic [1:0]   ord;

    s128_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid),
        .i_out_stall(i_stall), .i_sts(sts), .o_ctl(ctl),
        .o_stall(o_stall), .o_valid(o_valid)
    );

    s128_dp u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_ctl(ctl), .i_command(i_command),
        .i_a_low(i_a_low), .i_a_high(i_a_high), .i_b_low(i_b_low),
        .i_b_high(i_b_high), .o_sts(sts), .o_res(res), .o_order(ord),
        .o_dz(o_divide_by_zero)
    );

    assign o_result_low  = res[HW-1:0];
    assign o_result_high = res[W-1:HW];
    assign o_order       = ord;

endmodule

/* dv/signed_int128_alu_with_divider_tb.sv */
// Testbench for the 128-bit signed ALU: drives command/operand words, predicts
// each result in a scoreboard class and compares the whole word. Needs s128_pkg.
module signed_int128_alu_with_divider_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import s128_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;

    typedef struct packed {
        logic [63:0] res_low;
        logic [63:0] res_high;
        logic [1:0]  order;
        logic        div_zero;
    } t_alu_out;

    // predicts ALU results and holds them in order
    class alu_scoreboard;
        t_alu_out pending[$];
        int errors = 0;

        static function logic [1:0] ord_code(int v);
            return (v < 0) ? 2'b11 : v[1:0];
        endfunction

        static function t_alu_out compute(logic [3:0] cmd, logic [127:0] a, logic [127:0] b);
            t_alu_out r;
            logic [127:0] ua, ub, q, rm, res;
            logic a_neg, b_neg;
            r = '0;
            res = '0;
            a_neg = a[127];
            b_neg = b[127];
            ua = a_neg ? -a : a;
            ub = b_neg ? -b : b;
            case (cmd)
                CMD_ADD: res = a + b;
                CMD_SUB: res = a - b;
                CMD_MUL: res = a * b;
                CMD_DIV, CMD_MOD: begin
                    if (b == '0) begin
                        r.div_zero = 1'b1;
                    end else begin
                        q = ua / ub;
                        rm = ua % ub;
                        if (cmd == CMD_DIV) res = (a_neg != b_neg) ? -q : q;
                        else res = a_neg ? -rm : rm;
                    end
                end
                CMD_NEG: res = -a;
                CMD_ABS: res = ua;
                CMD_CMP: r.order = ord_code(($signed(a) < $signed(b)) ? -1 : (a == b ? 0 : 1));
                CMD_SGN: r.order = ord_code(a_neg ? -1 : (a == '0 ? 0 : 1));
                default: ;
            endcase
            r.res_low = res[63:0];
            r.res_high = res[127:64];
            return r;
        endfunction

        function void note_word(logic [3:0] cmd, logic [127:0] a, logic [127:0] b);
            pending.push_back(compute(cmd, a, b));
        endfunction

        function void check_word(t_alu_out got);
            t_alu_out exp;
            if (pending.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result word %h", got);
                return;
            end
            exp = pending.pop_front();
            if (got !== exp) begin
                errors++;
                if (errors <= 10)
                    $display({"mismatch: exp low %h high %h ord %b dz %b",
                              " / got low %h high %h ord %b dz %b"},
                             exp.res_low, exp.res_high, exp.order, exp.div_zero,
                             got.res_low, got.res_high, got.order, got.div_zero);
            end
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic o_stall;
    logic [3:0] i_command = '0;
    logic [63:0] i_a_low = '0, i_a_high = '0, i_b_low = '0, i_b_high = '0;
    logic o_valid;
    logic i_stall = 1'b1;
    logic [63:0] o_result_low, o_result_high;
    logic [1:0] o_order;
    logic o_divide_by_zero;

    alu_scoreboard sb = new();
    bit quiet = 1'b0;   // no idling on either side
    int idle_cycles = 0;

    always #10 i_clk = ~i_clk;

    signed_int128_alu_with_divider u_top (
        .i_clk, .i_rst_n, .i_valid, .o_stall, .i_command,
        .i_a_low, .i_a_high, .i_b_low, .i_b_high,
        .o_valid, .i_stall, .o_result_low, .o_result_high,
        .o_order, .o_divide_by_zero
    );

    // result side: sample at rising edge, stall changes at falling edge
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall)
            sb.check_word({o_result_low, o_result_high, o_order, o_divide_by_zero});
    end
    always @(negedge i_clk) begin
        i_stall <= !i_rst_n ? 1'b1 : (quiet ? 1'b0 : ($urandom_range(99) < 21));
    end

    // watchdog on cycles without any accepted word
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("signed_int128_alu_with_divider verification failed");
            $finish;
        end
    end

    function automatic logic [127:0] rand128();
        logic [127:0] v;
        case ($urandom_range(9))
            0: v = '0;
            1: v = '1;
            2: v = {1'b1, 127'b0};
            3: v = {1'b0, {127{1'b1}}};
            4: v = 128'd1;
            5: v = {{96{1'b0}}, 32'($urandom)};
            6: v = -{{96{1'b0}}, 32'($urandom)};
            7: v = {{64{1'b0}}, 32'($urandom), 32'($urandom)};
            default: v = {32'($urandom), 32'($urandom), 32'($urandom), 32'($urandom)};
        endcase
        return v;
    endfunction

    // one input word; valid held until accepted, lowered only when idling
    task automatic send_word(logic [3:0] cmd, logic [127:0] a, logic [127:0] b);
        while (!quiet && $urandom_range(99) < 21) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_command <= cmd;
        {i_a_high, i_a_low} <= a;
        {i_b_high, i_b_low} <= b;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        sb.note_word(cmd, a, b);
        @(negedge i_clk);
    endtask

    localparam logic [127:0] MIN128 = {1'b1, 127'b0};
    localparam logic [127:0] MAX128 = {1'b0, {127{1'b1}}};

    initial begin : main
        logic [3:0] cmd;
        logic [127:0] a, b;
        int wait_n;
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed corners
        for (int c = 0; c <= 8; c++) send_word(4'(c), MAX128, MIN128);
        send_word(CMD_DIV, MIN128, '1);
        send_word(CMD_MOD, MIN128, '1);
        send_word(CMD_DIV, 128'd7, '0);
        send_word(CMD_MOD, MIN128, '0);
        send_word(CMD_NEG, MIN128, '1);
        send_word(CMD_ABS, MIN128, '0);
        send_word(CMD_DIV, -128'sd7, 128'd2);
        send_word(CMD_MOD, -128'sd7, 128'd2);
        send_word(CMD_MOD, 128'd7, -128'sd2);
        send_word(CMD_CMP, 128'd5, 128'd5);
        send_word(CMD_SGN, '0, '1);
        send_word(CMD_MUL, '1, '1);
        send_word(4'd9, '1, '1);
        send_word(4'd15, MIN128, 128'd3);

        // random words; quiet stretch in the middle
        for (int n = 0; n < 950; n++) begin
            quiet = (n >= 300 && n < 450);
            cmd = ($urandom_range(19) == 0) ? 4'($urandom_range(15, 9))
                                            : 4'($urandom_range(8));
            a = rand128();
            b = rand128();
            send_word(cmd, a, b);
        end
        quiet = 1'b0;
        i_valid <= 1'b0;

        wait_n = 0;
        while (sb.pending.size() != 0 && wait_n < 100000) begin
            @(posedge i_clk);
            wait_n++;
        end
        repeat (150) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("signed_int128_alu_with_divider verification clean");
        else
            $display("signed_int128_alu_with_divider verification failed");
        $finish;
    end
endmodule
